// ===== design/first_fit_block_allocator_defines.svh =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator_defines.svh
// Assertion macros shared by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define FFBA_ASSERT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define FFBA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and codes of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int ADDR_W = 16;
  localparam int SIZE_W = 17;

  localparam logic [1:0] CMD_ALLOC = 2'd0;
  localparam logic [1:0] CMD_FREE  = 2'd1;
  localparam logic [1:0] CMD_QUERY = 2'd2;

  // Register index, taken from paddr[2]
  localparam logic REG_HEAP_LIMIT = 1'b0;
  localparam logic [SIZE_W-1:0] HEAP_LIMIT_RST = 17'h10000;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OOM      = 2'd1,
    ST_NULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] req_bytes;
    logic [ADDR_W-1:0] address;
  } ffba_in_t;

  typedef struct packed {
    status_t           status;
    logic [ADDR_W-1:0] address_out;
    logic [SIZE_W-1:0] used_bytes;
  } ffba_out_t;

  // Block header table entry
  typedef struct packed {
    logic [SIZE_W-1:0] start;
    logic [SIZE_W-1:0] size;
  } blk_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ffba_ctl_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic scan_end;
    logic out_free;
  } ffba_sts_t;

endpackage

// ===== design/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffba_ctrl
// Sequencer: capture a command, run the table walk, post the result.
// ----------------------------------------------------------------------------
module ffba_ctrl import ffba_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  ffba_sts_t sts,
  output ffba_ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ctl        = '0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        ctl.scan = 1'b1;
        if (sts.hit || sts.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        // wait for the output register to drain
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== design/ffba_dp.sv =====
// ----------------------------------------------------------------------------
// ffba_dp
// Header table memories, walk pipeline, heap top and result register.
// ----------------------------------------------------------------------------
module ffba_dp import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  ffba_ctl_t         ctl,
  output ffba_sts_t         sts,
  input  ffba_in_t          in_data,
  input  logic [SIZE_W-1:0] heap_limit,
  output logic              out_valid,
  input  logic              out_ready,
  output ffba_out_t         out_data
);

  localparam int IDX_W = $clog2(MAX_BLOCKS);
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam logic [SIZE_W-1:0] GROWTH_CAP =
    SIZE_W'((HEAP_BYTES < 65536) ? HEAP_BYTES : 65536);
  localparam logic [SIZE_W-1:0] HDR = SIZE_W'(HEADER_BYTES);
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_BLOCKS);

  blk_t blk_mem  [MAX_BLOCKS];
  logic free_mem [MAX_BLOCKS];

  logic [1:0]        cmd_q;
  logic [SIZE_W-1:0] need_q;
  logic [ADDR_W-1:0] addr_q;

  logic [CNT_W-1:0]  count;
  logic [SIZE_W-1:0] heap_top;
  logic [CNT_W-1:0]  rd_idx;
  logic              rd_vld;
  logic [IDX_W-1:0]  rd_tag;
  blk_t              rd_entry;
  logic              rd_free;
  logic              found;
  logic [SIZE_W-1:0] found_start;

  logic              is_alloc;
  logic              needs_scan;
  logic              hit_now;
  logic              issue;
  logic              append;
  logic              can_append;
  logic [SIZE_W:0]   sum_top;
  logic [SIZE_W-1:0] bound;
  logic [SIZE_W-1:0] pay;
  ffba_out_t         result;

  assign is_alloc   = (cmd_q == CMD_ALLOC);
  assign needs_scan = is_alloc || (cmd_q == CMD_FREE && addr_q != '0);

  // compare stage on registered table data
  always_comb begin
    hit_now = 1'b0;
    if (ctl.scan && rd_vld) begin
      if (is_alloc) begin
        hit_now = rd_free && (rd_entry.size >= need_q);
      end else begin
        hit_now = ({1'b0, rd_entry.start} + {1'b0, HDR}) == {2'b00, addr_q};
      end
    end
  end

  assign issue = ctl.scan && needs_scan && (rd_idx != count) && !hit_now;

  assign sts.hit      = hit_now;
  assign sts.scan_end = !needs_scan || ((rd_idx == count) && !rd_vld);
  assign sts.out_free = !out_valid || out_ready;

  // growth check for an append at the heap top
  assign sum_top    = {1'b0, heap_top} + {1'b0, need_q};
  assign bound      = (heap_limit < GROWTH_CAP) ? heap_limit : GROWTH_CAP;
  assign pay        = heap_top + HDR;
  assign can_append = (count != CNT_MAX) && (sum_top <= {1'b0, bound})
                      && (pay <= SIZE_W'(17'h0FFFF));
  assign append     = ctl.finish && is_alloc && !found && can_append;

  always_comb begin
    result.status      = ST_OK;
    result.address_out = '0;
    result.used_bytes  = append ? sum_top[SIZE_W-1:0] : heap_top;
    case (cmd_q)
      CMD_ALLOC: begin
        if (found) begin
          result.address_out = ADDR_W'(found_start + HDR);
        end else if (can_append) begin
          result.address_out = pay[ADDR_W-1:0];
        end else begin
          result.status = ST_OOM;
        end
      end
      CMD_FREE: begin
        if (addr_q == '0) begin
          result.status = ST_NULL;
        end else if (!found) begin
          result.status = ST_NOTFOUND;
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
  end

  // table memories: one read and one write port each, registered read
  always_ff @(posedge clk) begin
    if (issue) begin
      rd_entry <= blk_mem[rd_idx[IDX_W-1:0]];
      rd_free  <= free_mem[rd_idx[IDX_W-1:0]];
    end
    if (append) begin
      blk_mem[count[IDX_W-1:0]] <= '{start: heap_top, size: need_q};
    end
    if (hit_now) begin
      free_mem[rd_tag] <= !is_alloc;
    end else if (append) begin
      free_mem[count[IDX_W-1:0]] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_q  <= in_data.cmd;
      need_q <= {1'b0, in_data.req_bytes} + HDR;
      addr_q <= in_data.address;
    end
    if (issue) begin
      rd_tag <= rd_idx[IDX_W-1:0];
    end
    if (hit_now) begin
      found_start <= rd_entry.start;
    end
    if (ctl.finish) begin
      out_data <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      heap_top  <= '0;
      rd_idx    <= '0;
      rd_vld    <= 1'b0;
      found     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (ctl.load) begin
        rd_idx <= '0;
        found  <= 1'b0;
      end else if (issue) begin
        rd_idx <= rd_idx + CNT_W'(1);
      end
      if (hit_now) begin
        found <= 1'b1;
      end
      if (append) begin
        count    <= count + CNT_W'(1);
        heap_top <= sum_top[SIZE_W-1:0];
      end
      if (ctl.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== design/first_fit_block_allocator.sv =====
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap allocator with a header table, no splitting or merging.
// ----------------------------------------------------------------------------
// Input channel in_valid/in_ready/in_data carries one command: allocate,
// free or query (an unused code acts as a query). Output channel
// out_valid/out_ready/out_data returns exactly one result per command.
// An APB-style port holds heap_limit at byte address 0; write it only
// while no transaction is in flight.
// A query or a null free passes through the walk state, which ends at once,
// to the finish state and out_valid. An allocate or free walks the header
// table one entry per cycle through the registered memory read, until an
// entry matches or all count entries have been read (count is the number
// of blocks, at most MAX_BLOCKS; no entry is read on an empty table). One
// command is worked on at a time; the next is accepted as soon as the
// previous result sits in the output register.
// Reset clears the block count and heap top and sets heap_limit to 65536;
// the table itself needs no clearing. A stalled receiver holds the result
// register, and a finished command then waits until it drains.
// ----------------------------------------------------------------------------
module first_fit_block_allocator import ffba_pkg::*; #(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEAP_BYTES   = 65536,
  parameter int HEADER_BYTES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  ffba_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ffba_out_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [SIZE_W-1:0] heap_limit;
  logic              reg_sel;
  ffba_ctl_t         ctl;
  ffba_sts_t         sts;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_HEAP_LIMIT);
  assign prdata  = reg_sel ? {15'd0, heap_limit} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      heap_limit <= HEAP_LIMIT_RST;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      heap_limit <= pwdata[SIZE_W-1:0];
    end
  end

  ffba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .ctl      (ctl)
  );

  ffba_dp #(
    .MAX_BLOCKS   (MAX_BLOCKS),
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .sts        (sts),
    .in_data    (in_data),
    .heap_limit (heap_limit),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

// ===== design/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`include "first_fit_block_allocator_defines.svh"

module ffba_checker import ffba_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input ffba_in_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input ffba_out_t out_data
);

  logic [1:0] pend;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // commands accepted whose result has not been taken yet
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(in_acc) - 2'(out_acc);
    end
  end

  `FFBA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")
  `FFBA_ASSERT(a_no_extra, out_valid, pend != 2'd0, "result without a pending transaction")
  `FFBA_ASSERT(a_depth, in_acc || out_acc || 1'b1, pend != 2'd3, "more than two transactions in flight")
  `FFBA_ASSERT(a_err_addr, out_valid && out_data.status != ST_OK, out_data.address_out == '0, "address on error")
  `FFBA_ASSERT(a_rst_out, $past(rst), !out_valid, "result valid right after reset")

endmodule

bind first_fit_block_allocator ffba_checker u_ffba_checker (.*);

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the first-fit block allocator. A directed table
// walks the null, unknown, double and reused free paths and growth past the
// heap, then random command mixes run under several heap_limit settings and
// handshake idling patterns. Typed directed rows are checked against their
// listed results, all others against an in-bench mirror of the header table.
// ----------------------------------------------------------------------------
module testbench;
  import ffba_pkg::*;

  localparam int          MAX_BLOCKS   = 64;
  localparam int          HEAP_BYTES   = 65536;
  localparam int unsigned HEADER_BYTES = 16;
  localparam logic [1:0]  CMD_SPARE    = 2'd3;  // unused code, behaves as a query
  localparam logic [2:0]  LIMIT_ADDR   = {REG_HEAP_LIMIT, 2'b00};
  localparam int          SHOW_MAX     = 40;
  localparam int          HOLD_CYCLES  = 300;

  localparam ffba_out_t NO_WANT = '{ST_OK, 16'd0, 17'd0};

  typedef struct {
    ffba_in_t  op;
    bit        typed;
    ffba_out_t want;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  ffba_in_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  ffba_out_t   out_data;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // mirror of the allocator state
  logic [SIZE_W-1:0] blk_start_m [MAX_BLOCKS];
  logic [SIZE_W-1:0] blk_size_m  [MAX_BLOCKS];
  bit                blk_free_m  [MAX_BLOCKS];
  int unsigned       blk_cnt  = 0;
  logic [SIZE_W-1:0] top_m    = '0;
  logic [SIZE_W-1:0] limit_m  = HEAP_LIMIT_RST;

  ffba_out_t owed_results[$];
  int        mismatch_cnt = 0;
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        hold_ask = 0;
  int        hold_left = 0;

  dir_row_t dir_rows [20] = '{
    '{'{CMD_QUERY, 16'd0,      16'd0},      1'b1, '{ST_OK,       16'd0,  17'd0}},
    '{'{CMD_FREE,  16'd0,      16'd0},      1'b1, '{ST_NULL,     16'd0,  17'd0}},
    '{'{CMD_FREE,  16'd0,      16'hFFFF},   1'b1, '{ST_NOTFOUND, 16'd0,  17'd0}},
    '{'{CMD_ALLOC, 16'd0,      16'd0},      1'b1, '{ST_OK,       16'd16, 17'd16}},
    '{'{CMD_ALLOC, 16'hFFFF,   16'd0},      1'b1, '{ST_OOM,      16'd0,  17'd16}},
    '{'{CMD_ALLOC, 16'd100,    16'd0},      1'b1, '{ST_OK,       16'd32, 17'd132}},
    '{'{CMD_FREE,  16'd0,      16'd32},     1'b1, '{ST_OK,       16'd0,  17'd132}},
    '{'{CMD_FREE,  16'd0,      16'd32},     1'b1, '{ST_OK,       16'd0,  17'd132}},
    '{'{CMD_ALLOC, 16'd50,     16'd0},      1'b1, '{ST_OK,       16'd32, 17'd132}},
    '{'{CMD_FREE,  16'd0,      16'd16},     1'b1, '{ST_OK,       16'd0,  17'd132}},
    '{'{CMD_ALLOC, 16'd0,      16'd0},      1'b0, NO_WANT},
    '{'{CMD_ALLOC, 16'd1,      16'd0},      1'b0, NO_WANT},
    '{'{CMD_SPARE, 16'd0,      16'd0},      1'b0, NO_WANT},
    '{'{CMD_FREE,  16'd0,      16'd17},     1'b0, NO_WANT},
    '{'{CMD_FREE,  16'd0,      16'd148},    1'b0, NO_WANT},
    '{'{CMD_ALLOC, 16'd0,      16'd0},      1'b0, NO_WANT},
    '{'{CMD_ALLOC, 16'd200,    16'hFFFF},   1'b0, NO_WANT},
    '{'{CMD_FREE,  16'hFFFF,   16'd16},     1'b0, NO_WANT},
    '{'{CMD_QUERY, 16'hFFFF,   16'hFFFF},   1'b0, NO_WANT},
    '{'{CMD_FREE,  16'hFFFF,   16'd0},      1'b0, NO_WANT}
  };

  first_fit_block_allocator #(
    .MAX_BLOCKS  (MAX_BLOCKS),
    .HEAP_BYTES  (HEAP_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Updates the mirrored heap for one accepted command, returns its result
  function automatic ffba_out_t heap_step(input ffba_in_t op);
    ffba_out_t   r;
    int unsigned need;
    int unsigned bound;
    int unsigned pay;
    int unsigned i;
    bit          granted;
    r       = NO_WANT;
    granted = 1'b0;
    if (op.cmd == CMD_ALLOC) begin
      need = op.req_bytes + HEADER_BYTES;
      for (i = 0; i < blk_cnt; i++) begin
        if (blk_free_m[i] && blk_size_m[i] >= need) begin
          blk_free_m[i] = 1'b0;
          r.address_out = 16'(blk_start_m[i] + HEADER_BYTES);
          granted       = 1'b1;
          break;
        end
      end
      if (!granted) begin
        bound = (limit_m < HEAP_BYTES) ? limit_m : HEAP_BYTES;
        if (bound > 65536) bound = 65536;
        pay = top_m + HEADER_BYTES;
        if (blk_cnt >= MAX_BLOCKS || top_m + need > bound || pay > 16'hFFFF) begin
          r.status = ST_OOM;
        end else begin
          blk_start_m[blk_cnt] = top_m;
          blk_size_m[blk_cnt]  = need[SIZE_W-1:0];
          blk_free_m[blk_cnt]  = 1'b0;
          blk_cnt++;
          top_m         = top_m + need[SIZE_W-1:0];
          r.address_out = pay[ADDR_W-1:0];
        end
      end
    end else if (op.cmd == CMD_FREE) begin
      if (op.address == '0) begin
        r.status = ST_NULL;
      end else begin
        r.status = ST_NOTFOUND;
        for (i = 0; i < blk_cnt; i++) begin
          if (blk_start_m[i] + HEADER_BYTES == op.address) begin
            blk_free_m[i] = 1'b1;
            r.status      = ST_OK;
            break;
          end
        end
      end
    end
    r.used_bytes = top_m;
    return r;
  endfunction

  // Mostly allocations and frees, many sized to fit or aimed at existing blocks
  function automatic ffba_in_t rand_cmd();
    ffba_in_t op;
    int       pick;
    int       sel;
    int       k;
    int       req;
    op.req_bytes = 16'($urandom);
    op.address   = 16'($urandom);
    pick = $urandom_range(0, 99);
    sel  = $urandom_range(0, 9);
    k    = (blk_cnt > 0) ? $urandom_range(0, blk_cnt - 1) : 0;
    if (pick < 45) begin
      op.cmd = CMD_ALLOC;
      if (sel < 4 && blk_cnt > 0) begin
        req = int'(blk_size_m[k]) - int'(HEADER_BYTES) - int'($urandom_range(0, 8));
        if (req < 0) req = 0;
        if (req > 65535) req = 65535;
        op.req_bytes = 16'(req);
      end else if (sel < 8) begin
        op.req_bytes = 16'($urandom_range(0, 255));
      end else if (sel < 9) begin
        op.req_bytes = 16'($urandom_range(0, 4095));
      end
    end else if (pick < 85) begin
      op.cmd = CMD_FREE;
      if (sel < 7 && blk_cnt > 0) begin
        op.address = 16'(blk_start_m[k] + HEADER_BYTES);
      end else if (sel < 8) begin
        op.address = '0;
      end else if (sel < 9 && blk_cnt > 0) begin
        op.address = 16'(blk_start_m[k] + HEADER_BYTES + $urandom_range(1, 3));
      end
    end else begin
      op.cmd = ($urandom_range(0, 3) == 0) ? CMD_SPARE : CMD_QUERY;
    end
    return op;
  endfunction

  task automatic issue_cmd(input ffba_in_t op, input bit typed, input ffba_out_t want);
    ffba_out_t r;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= op;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = heap_step(op);
    owed_results.push_back(typed ? want : r);
  endtask

  task automatic write_heap_limit(input logic [SIZE_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= 32'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    limit_m = val;
  endtask

  task automatic run_phase(input logic [SIZE_W-1:0] limit, input int in_idle,
                           input int out_stall, input int n, input int hold_at);
    ffba_in_t op;
    write_heap_limit(limit);
    idle_pct  = in_idle;
    stall_pct = out_stall;
    for (int j = 0; j < n; j++) begin
      if (j == hold_at) hold_ask = HOLD_CYCLES;
      op = rand_cmd();
      issue_cmd(op, 1'b0, NO_WANT);
    end
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_result(input ffba_out_t got);
    ffba_out_t want;
    if (owed_results.size() == 0) begin
      mismatch_cnt++;
      if (mismatch_cnt <= SHOW_MAX)
        $display("%0t: result with none pending: status=%0d address_out=%0d used_bytes=%0d",
                 $time, got.status, got.address_out, got.used_bytes);
      return;
    end
    want = owed_results.pop_front();
    if (got.status !== want.status || got.address_out !== want.address_out ||
        got.used_bytes !== want.used_bytes) begin
      mismatch_cnt++;
      if (mismatch_cnt <= SHOW_MAX)
        $display("%0t: expected status=%0d address_out=%0d used_bytes=%0d, got %0d %0d %0d",
                 $time, want.status, want.address_out, want.used_bytes,
                 got.status, got.address_out, got.used_bytes);
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) check_result(out_data);
  end

  // Receiver: random stalls, plus one long hold-off that backs up the block
  always @(posedge clk) begin
    if (hold_ask != 0) begin
      hold_left = hold_ask;
      hold_ask  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[n]) issue_cmd(dir_rows[n].op, dir_rows[n].typed, dir_rows[n].want);
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);

    // limit 0 blocks all growth; a small limit trips the bound before the
    // table fills; the full limit lets the table reach MAX_BLOCKS
    run_phase(17'd0, 0, 0, 100, -1);
    run_phase(17'($urandom_range(600, 4000)), 61, 0, 350, -1);
    run_phase(HEAP_LIMIT_RST, 0, 61, 400, 10);
    run_phase(17'($urandom_range(0, 65536)), 23, 23, 400, -1);
    run_phase(17'd1, 0, 0, 150, -1);
    run_phase(HEAP_LIMIT_RST, 23, 23, 350, -1);

    repeat (80) @(posedge clk);
    if (mismatch_cnt == 0 && owed_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
